### hw/rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset gated
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset gated
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/mfm_enc_pkg.sv
// shared sizes, constants and types of the mfm sector encoder
package mfm_enc_pkg;

  // sector geometry
  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned SECTOR_BYTES = 64 + 2 * BLOCK_BYTES;
  localparam int unsigned HEAD_BYTES   = 64;
  localparam int unsigned INDEX_W      = 11;
  localparam int unsigned ADDR_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned LOAD_W       = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned POS_W        =
    ($clog2(SECTOR_BYTES) > INDEX_W) ? $clog2(SECTOR_BYTES) : INDEX_W;
  localparam int unsigned STEP_W       = 4;

  // index of the final byte as seen on the byte_index port
  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'((SECTOR_BYTES - 1) % 2048);

  // fixed byte patterns
  localparam logic [7:0]  PRE_MARK_BYTE = 8'h2A;
  localparam logic [7:0]  FILL_BYTE     = 8'hAA;
  localparam logic [7:0]  SYNC_HI_BYTE  = 8'h44;
  localparam logic [7:0]  SYNC_LO_BYTE  = 8'h89;
  localparam logic [7:0]  INFO_MARK     = 8'hFF;
  localparam logic [7:0]  SECTOR_BASE   = 8'd11;
  localparam logic [7:0]  DATA_MASK     = 8'h55;
  localparam logic [7:0]  CLOCK_MASK    = 8'hAA;
  localparam logic [7:0]  PREV_RESET    = 8'hAA;
  localparam logic [31:0] LONG_MASK     = 32'h5555_5555;

  // commands on the input channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // byte source chosen by a control word
  typedef enum logic [2:0] {
    SRC_PRE0,
    SRC_FILL,
    SRC_SYNC,
    SRC_INFO,
    SRC_HCHK,
    SRC_DCHK,
    SRC_DATA
  } src_e;

  // one control word of the sequencer program
  typedef struct packed {
    src_e             src;
    logic             odd;
    logic             clk_en;
    logic             last;
    logic [POS_W-1:0] end_pos;
  } ucode_t;

endpackage

### hw/rtl/mfm_sector_encoder_core.sv
// mfm sector encoder: buffer, microcode sequencer and byte datapath
//
// Load items (command 0) fill the sector buffer one byte per cycle; the first
// load of a sector latches track and sector numbers. Once the buffer holds
// BLOCK_BYTES bytes, each emit item (command 1) yields the next byte of the
// 64 + 2*BLOCK_BYTES byte MFM sector with its position and a last flag;
// emits before that, and loads after it, are taken and dropped. A load or a
// dropped item does not stall the input. An emit reads the sector buffer into
// a register, then forms and clock-encodes the byte; the input stalls until
// the byte is in the output register, so no item is taken meanwhile. A small
// program in a read-only table, one control word per sector segment, selects
// the byte source and half and jumps on the segment's end position.
module mfm_sector_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] track_number_i,
  input  logic [7:0] sector_number_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] mfm_byte_o,
  output logic [mfm_enc_pkg::INDEX_W-1:0] byte_index_o,
  output logic       last_o
);

  typedef enum logic {ST_IDLE, ST_FORM} state_e;

  typedef enum logic [mfm_enc_pkg::STEP_W-1:0] {
    STEP_PRE0,
    STEP_PRE,
    STEP_SYNC,
    STEP_INFO_ODD,
    STEP_INFO_EVEN,
    STEP_GAP,
    STEP_HCHK_ODD,
    STEP_HCHK_EVEN,
    STEP_DCHK_ODD,
    STEP_DCHK_EVEN,
    STEP_DATA_ODD,
    STEP_DATA_EVEN
  } step_e;

  // sequencer program, one word per segment
  function automatic mfm_enc_pkg::ucode_t ucode(input step_e s);
    mfm_enc_pkg::ucode_t w;
    w = '{src: mfm_enc_pkg::SRC_FILL, odd: 1'b0, clk_en: 1'b0, last: 1'b0,
          end_pos: '0};
    unique case (s)
      STEP_PRE0: begin
        w.src = mfm_enc_pkg::SRC_PRE0; w.end_pos = mfm_enc_pkg::POS_W'(0);
      end
      STEP_PRE: begin
        w.src = mfm_enc_pkg::SRC_FILL; w.end_pos = mfm_enc_pkg::POS_W'(3);
      end
      STEP_SYNC: begin
        w.src = mfm_enc_pkg::SRC_SYNC; w.end_pos = mfm_enc_pkg::POS_W'(7);
      end
      STEP_INFO_ODD: begin
        w.src = mfm_enc_pkg::SRC_INFO; w.odd = 1'b1; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(11);
      end
      STEP_INFO_EVEN: begin
        w.src = mfm_enc_pkg::SRC_INFO; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(15);
      end
      STEP_GAP: begin
        w.src = mfm_enc_pkg::SRC_FILL; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(47);
      end
      STEP_HCHK_ODD: begin
        w.src = mfm_enc_pkg::SRC_HCHK; w.odd = 1'b1; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(51);
      end
      STEP_HCHK_EVEN: begin
        w.src = mfm_enc_pkg::SRC_HCHK; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(55);
      end
      STEP_DCHK_ODD: begin
        w.src = mfm_enc_pkg::SRC_DCHK; w.odd = 1'b1; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(59);
      end
      STEP_DCHK_EVEN: begin
        w.src = mfm_enc_pkg::SRC_DCHK; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(63);
      end
      STEP_DATA_ODD: begin
        w.src = mfm_enc_pkg::SRC_DATA; w.odd = 1'b1; w.clk_en = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(mfm_enc_pkg::HEAD_BYTES +
                                        mfm_enc_pkg::BLOCK_BYTES - 1);
      end
      STEP_DATA_EVEN: begin
        w.src = mfm_enc_pkg::SRC_DATA; w.clk_en = 1'b1; w.last = 1'b1;
        w.end_pos = mfm_enc_pkg::POS_W'(mfm_enc_pkg::SECTOR_BYTES - 1);
      end
      default: begin
        w.src = mfm_enc_pkg::SRC_FILL;
      end
    endcase
    return w;
  endfunction

  // keep the data bits, set a clock bit where both neighbors are zero
  function automatic logic [7:0] with_clock(input logic [7:0] raw, input logic prev_lsb);
    logic [7:0] d;
    logic [7:0] lft;
    logic [7:0] rgt;
    d   = raw & mfm_enc_pkg::DATA_MASK;
    lft = {d[6:0], 1'b0};
    rgt = {prev_lsb, d[7:1]};
    return d | (~(lft | rgt) & mfm_enc_pkg::CLOCK_MASK);
  endfunction

  // odd half xor even half of a long
  function automatic logic [31:0] fold_long(input logic [31:0] v);
    return ((v >> 1) & mfm_enc_pkg::LONG_MASK) ^ (v & mfm_enc_pkg::LONG_MASK);
  endfunction

  state_e                          state_q;
  step_e                           step_q;
  logic [mfm_enc_pkg::POS_W-1:0]   emit_q;
  logic [mfm_enc_pkg::LOAD_W-1:0]  load_q;
  logic [31:0]                     xor_q;
  logic [7:0]                      track_q;
  logic [7:0]                      sector_q;
  logic [7:0]                      prev_q;
  logic                            out_valid_q;
  logic [7:0]                      mfm_q;
  logic [mfm_enc_pkg::INDEX_W-1:0] index_q;
  logic                            last_q;
  logic [7:0]                      buf_mem [mfm_enc_pkg::BLOCK_BYTES];
  logic [7:0]                      rd_q;

  mfm_enc_pkg::ucode_t             cw;
  logic                            in_fire;
  logic                            loaded;
  logic                            load_fire;
  logic                            emit_fire;
  logic                            out_free;
  logic                            form_done;
  logic                            seg_end;
  logic                            sector_end;
  logic [mfm_enc_pkg::POS_W-1:0]   data_off;
  logic [mfm_enc_pkg::ADDR_W-1:0]  rd_addr;
  logic [31:0]                     load_long;
  logic [31:0]                     info_long;
  logic [31:0]                     src_long;
  logic [7:0]                      src_byte;
  logic [7:0]                      raw_byte;
  logic [7:0]                      byte_out;

  // handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign loaded     = (load_q == mfm_enc_pkg::LOAD_W'(mfm_enc_pkg::BLOCK_BYTES));
  assign load_fire  = in_fire && (command_i == mfm_enc_pkg::CMD_LOAD) && !loaded;
  assign emit_fire  = in_fire && (command_i == mfm_enc_pkg::CMD_EMIT) && loaded;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign form_done  = (state_q == ST_FORM) && out_free;

  // current control word and jump conditions
  assign cw         = ucode(step_q);
  assign seg_end    = (emit_q == cw.end_pos);
  assign sector_end = seg_end && cw.last;

  // buffer address for the current data position
  assign data_off = emit_q - mfm_enc_pkg::POS_W'(mfm_enc_pkg::HEAD_BYTES)
                  - (cw.odd ? '0 : mfm_enc_pkg::POS_W'(mfm_enc_pkg::BLOCK_BYTES));
  assign rd_addr  = data_off[mfm_enc_pkg::ADDR_W-1:0];

  // sector buffer, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      buf_mem[load_q[mfm_enc_pkg::ADDR_W-1:0]] <= data_byte_i;
    end
    rd_q <= buf_mem[rd_addr];
  end

  // loaded byte placed in its big-endian long slot
  assign load_long = {24'd0, data_byte_i} << {~load_q[1:0], 3'b000};

  // info long and long source select
  assign info_long = {mfm_enc_pkg::INFO_MARK, track_q, sector_q,
                      mfm_enc_pkg::SECTOR_BASE - sector_q};

  always_comb begin
    case (cw.src)
      mfm_enc_pkg::SRC_HCHK: src_long = fold_long(info_long);
      mfm_enc_pkg::SRC_DCHK: src_long = fold_long(xor_q);
      default:               src_long = info_long;
    endcase
  end

  // raw byte before clock insertion
  always_comb begin
    src_byte = src_long[{~emit_q[1:0], 3'b000} +: 8];
    if (cw.src == mfm_enc_pkg::SRC_DATA) begin
      src_byte = rd_q;
    end
    case (cw.src)
      mfm_enc_pkg::SRC_PRE0:
        raw_byte = prev_q[0] ? mfm_enc_pkg::PRE_MARK_BYTE : mfm_enc_pkg::FILL_BYTE;
      mfm_enc_pkg::SRC_FILL:
        raw_byte = mfm_enc_pkg::FILL_BYTE;
      mfm_enc_pkg::SRC_SYNC:
        raw_byte = emit_q[0] ? mfm_enc_pkg::SYNC_LO_BYTE : mfm_enc_pkg::SYNC_HI_BYTE;
      default:
        raw_byte = cw.odd ? ((src_byte >> 1) & mfm_enc_pkg::DATA_MASK)
                          : (src_byte & mfm_enc_pkg::DATA_MASK);
    endcase
  end

  assign byte_out = cw.clk_en ? with_clock(raw_byte, prev_q[0]) : raw_byte;

  // sequencer state, counters and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_PRE0;
      emit_q      <= '0;
      load_q      <= '0;
      xor_q       <= '0;
      track_q     <= '0;
      sector_q    <= '0;
      prev_q      <= mfm_enc_pkg::PREV_RESET;
      out_valid_q <= 1'b0;
      mfm_q       <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (emit_fire) begin
            state_q <= ST_FORM;
          end
        end
        ST_FORM: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (load_fire) begin
        if (load_q == '0) begin
          track_q  <= track_number_i;
          sector_q <= sector_number_i;
          xor_q    <= load_long;
        end else begin
          xor_q    <= xor_q ^ load_long;
        end
        load_q <= load_q + 1'b1;
      end

      if (form_done) begin
        prev_q <= byte_out;
        if (sector_end) begin
          emit_q <= '0;
          load_q <= '0;
          xor_q  <= '0;
          step_q <= STEP_PRE0;
        end else begin
          emit_q <= emit_q + 1'b1;
          if (seg_end) begin
            step_q <= step_e'(step_q + 1'b1);
          end
        end
      end

      if (form_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // output payload
      if (form_done) begin
        mfm_q   <= byte_out;
        index_q <= emit_q[mfm_enc_pkg::INDEX_W-1:0];
        last_q  <= sector_end;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mfm_byte_o   = mfm_q;
  assign byte_index_o = index_q;
  assign last_o       = last_q;

endmodule

### hw/rtl/mfm_enc_checker.sv
// port-level checks of the mfm sector encoder, bound to the encoder core
`include "assert_macros.svh"

module mfm_enc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] mfm_byte_o,
  input logic [mfm_enc_pkg::INDEX_W-1:0] byte_index_o,
  input logic       last_o
);

  logic [mfm_enc_pkg::INDEX_W-1:0] exp_index_q;

  // expected position of the next delivered byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_index_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_index_q <= last_o ? '0 : exp_index_q + 1'b1;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(mfm_byte_o) && $stable(byte_index_o) && $stable(last_o))
  `ASSERT_NOW(a_index_order, clk_i, rst_ni, out_valid_o, byte_index_o == exp_index_q)
  `ASSERT_NOW(a_last_index, clk_i, rst_ni, out_valid_o, last_o == (byte_index_o == mfm_enc_pkg::LAST_INDEX))
  `ASSERT_NOW(a_sync_word, clk_i, rst_ni, out_valid_o && (byte_index_o[mfm_enc_pkg::INDEX_W-1:2] == 1), mfm_byte_o == (byte_index_o[0] ? mfm_enc_pkg::SYNC_LO_BYTE : mfm_enc_pkg::SYNC_HI_BYTE))
  `ASSERT_NOW(a_preamble, clk_i, rst_ni, out_valid_o && (byte_index_o == 0), mfm_byte_o == mfm_enc_pkg::PRE_MARK_BYTE || mfm_byte_o == mfm_enc_pkg::FILL_BYTE)

endmodule

bind mfm_sector_encoder_core mfm_enc_checker u_mfm_enc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mfm_byte_o   (mfm_byte_o),
  .byte_index_o (byte_index_o),
  .last_o       (last_o)
);

### tb/tb_top.sv
// testbench for the mfm sector encoder core: sector bytes checked against a byte predictor
`timescale 1ns / 100ps

// one expected output transfer
typedef struct packed {
  logic [7:0]                      mfm_byte;
  logic [mfm_enc_pkg::INDEX_W-1:0] index;
  logic                            last;
} mfm_out_t;

// tracks buffer, counters and checksum, predicts each emitted byte
class mfm_sector_scoreboard;
  logic [7:0]  buffer [mfm_enc_pkg::BLOCK_BYTES];
  int unsigned loaded;
  int unsigned emitted;
  logic [31:0] data_sum;
  logic [7:0]  track;
  logic [7:0]  sector;
  logic [7:0]  prev_byte;
  mfm_out_t    pending_bytes [$];
  int unsigned errors;

  function new();
    loaded    = 0;
    emitted   = 0;
    data_sum  = '0;
    track     = '0;
    sector    = '0;
    prev_byte = mfm_enc_pkg::PREV_RESET;
    errors    = 0;
  endfunction

  function logic [7:0] odd_half(logic [7:0] b);
    return (b >> 1) & mfm_enc_pkg::DATA_MASK;
  endfunction

  function logic [7:0] even_half(logic [7:0] b);
    return b & mfm_enc_pkg::DATA_MASK;
  endfunction

  // byte k of a big-endian long
  function logic [7:0] long_byte(logic [31:0] v, int unsigned k);
    return 8'(v >> (8 * (3 - k)));
  endfunction

  // checksum form of a long: odd half xor even half
  function logic [31:0] fold(logic [31:0] v);
    return ((v >> 1) & mfm_enc_pkg::LONG_MASK) ^ (v & mfm_enc_pkg::LONG_MASK);
  endfunction

  // sector byte at position p before clock insertion
  function logic [7:0] plain_byte(int unsigned p);
    logic [31:0] info;
    info = {mfm_enc_pkg::INFO_MARK, track, sector, 8'(mfm_enc_pkg::SECTOR_BASE - sector)};
    if (p == 0) return prev_byte[0] ? mfm_enc_pkg::PRE_MARK_BYTE : mfm_enc_pkg::FILL_BYTE;
    if (p < 4) return mfm_enc_pkg::FILL_BYTE;
    if (p < 8) return (p % 2 == 1) ? mfm_enc_pkg::SYNC_LO_BYTE : mfm_enc_pkg::SYNC_HI_BYTE;
    if (p < 12) return odd_half(long_byte(info, p - 8));
    if (p < 16) return even_half(long_byte(info, p - 12));
    if (p < 48) return mfm_enc_pkg::FILL_BYTE;
    if (p < 52) return odd_half(long_byte(fold(info), p - 48));
    if (p < 56) return even_half(long_byte(fold(info), p - 52));
    if (p < 60) return odd_half(long_byte(fold(data_sum), p - 56));
    if (p < mfm_enc_pkg::HEAD_BYTES) return even_half(long_byte(fold(data_sum), p - 60));
    if (p < mfm_enc_pkg::HEAD_BYTES + mfm_enc_pkg::BLOCK_BYTES)
      return odd_half(buffer[p - mfm_enc_pkg::HEAD_BYTES]);
    return even_half(buffer[p - mfm_enc_pkg::HEAD_BYTES - mfm_enc_pkg::BLOCK_BYTES]);
  endfunction

  // keep data bits, set a clock bit where both neighbors are zero
  function logic [7:0] add_clock(logic [7:0] raw, logic prev_bit);
    logic [7:0] d;
    logic [7:0] left;
    logic [7:0] right;
    d     = raw & mfm_enc_pkg::DATA_MASK;
    left  = d << 1;
    right = {prev_bit, d[7:1]};
    return d | (~(left | right) & mfm_enc_pkg::CLOCK_MASK);
  endfunction

  // accepted input transfer: update state, queue a byte for an emit
  function void note_input(logic cmd, logic [7:0] db, logic [7:0] trk, logic [7:0] sec);
    mfm_out_t   r;
    logic [7:0] b;
    if (cmd == mfm_enc_pkg::CMD_LOAD) begin
      if (loaded < mfm_enc_pkg::BLOCK_BYTES) begin
        if (loaded == 0) begin
          track    = trk;
          sector   = sec;
          data_sum = '0;
        end
        buffer[loaded] = db;
        data_sum ^= 32'(db) << (8 * (3 - loaded % 4));
        loaded++;
      end
    end else if (loaded == mfm_enc_pkg::BLOCK_BYTES) begin
      b = plain_byte(emitted);
      if (emitted >= 8) b = add_clock(b, prev_byte[0]);
      prev_byte  = b;
      r.mfm_byte = b;
      r.index    = mfm_enc_pkg::INDEX_W'(emitted);
      r.last     = (emitted + 1 == mfm_enc_pkg::SECTOR_BYTES);
      pending_bytes.push_back(r);
      if (emitted + 1 == mfm_enc_pkg::SECTOR_BYTES) begin
        emitted  = 0;
        loaded   = 0;
        data_sum = '0;
      end else begin
        emitted++;
      end
    end
  endfunction

  function void flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  // accepted output transfer against the oldest expected byte
  function void check_result(logic [7:0] b, logic [mfm_enc_pkg::INDEX_W-1:0] idx, logic lst);
    mfm_out_t want;
    if (pending_bytes.size() == 0) begin
      errors++;
      $display("%0t: output transfer with none expected: byte %h index %0d", $time, b, idx);
      return;
    end
    want = pending_bytes.pop_front();
    if (b !== want.mfm_byte) flag_mismatch("mfm_byte", 16'(want.mfm_byte), 16'(b));
    if (idx !== want.index) flag_mismatch("byte_index", 16'(want.index), 16'(idx));
    if (lst !== want.last) flag_mismatch("last", 16'(want.last), 16'(lst));
  endfunction
endclass

module tb_top;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned GAP_EMITS    = 80;
  localparam int unsigned TAIL_EMITS   = 30;
  // first bytes of the data block: data extremes and single-bit patterns
  localparam logic [63:0] HEAD_PATTERN = 64'h00FF_55AA_0180_7FFE;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic                            in_command = mfm_enc_pkg::CMD_LOAD;
  logic [7:0]                      in_data    = '0;
  logic [7:0]                      in_track   = '0;
  logic [7:0]                      in_sector  = '0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic [7:0]                      mfm_byte;
  logic [mfm_enc_pkg::INDEX_W-1:0] byte_index;
  logic                            last_byte;

  bit                  gaps_on    = 1'b1;
  int unsigned         stall_left = 0;
  int unsigned         quiet_cycles = 0;
  mfm_sector_scoreboard sb;

  mfm_sector_encoder_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (in_command),
    .data_byte_i     (in_data),
    .track_number_i  (in_track),
    .sector_number_i (in_sector),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .mfm_byte_o      (mfm_byte),
    .byte_index_o    (byte_index),
    .last_o          (last_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one input transfer, called at a falling edge, returns at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] db, trk, sec);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_data    <= db;
    in_track   <= trk;
    in_sector  <= sec;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, db, trk, sec);
    @(negedge clk);
  endtask

  // emits of sector bytes, with ignored loads on the full buffer mixed in
  task automatic emit_bytes(input int unsigned count);
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(mfm_enc_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      send_item(mfm_enc_pkg::CMD_EMIT, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // load a full buffer then emit the head of the sector, with stray commands mixed in
  task automatic run_sector(input logic [7:0] trk, sec, input bit directed_head,
                            input int unsigned count);
    logic [7:0] db;
    for (int i = 0; i < mfm_enc_pkg::BLOCK_BYTES; i++) begin
      // emit while the buffer is still filling is dropped
      if ($urandom_range(0, 19) == 0)
        send_item(mfm_enc_pkg::CMD_EMIT, 8'($urandom), 8'($urandom), 8'($urandom));
      db = 8'($urandom);
      if (directed_head && i < 8) db = HEAD_PATTERN[63 - 8 * i -: 8];
      send_item(mfm_enc_pkg::CMD_LOAD, db, (i == 0) ? trk : 8'($urandom),
                (i == 0) ? sec : 8'($urandom));
    end
    emit_bytes(count);
  endtask

  // random receiver stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(mfm_byte, byte_index, last_byte);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // emits right after reset, nothing loaded yet
    send_item(mfm_enc_pkg::CMD_EMIT, 8'h00, 8'h00, 8'h00);
    send_item(mfm_enc_pkg::CMD_EMIT, 8'hFF, 8'hFF, 8'hFF);
    send_item(mfm_enc_pkg::CMD_EMIT, 8'h5A, 8'hA5, 8'h3C);
    // field extremes on track and sector, the complement byte wraps
    run_sector(8'hFF, 8'hFF, 1'b1, GAP_EMITS);
    // last part runs without idling
    gaps_on = 1'b0;
    emit_bytes(TAIL_EMITS);
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
